@@ rtl/ntfsdr_pkg.sv @@
// Shared types and constants for the NTFS run-list decoder.
// No dependencies; imported by ntfsdr_decode and the top level.
package ntfsdr_pkg;

    // Result kinds
    localparam logic [1:0] KIND_RUN   = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_TRUNC = 2'd2;

    // Configuration port geometry: registers on 8-byte spacing, 64-bit data
    localparam int ADDR_W = 4;
    localparam int DATA_W = 64;
    localparam int SPC_W  = 13;

    localparam logic [SPC_W-1:0] SPC_RESET = 13'd8;

    // Register index as seen on paddr[3]
    localparam logic REG_VOLUME_START        = 1'b0;
    localparam logic REG_SECTORS_PER_CLUSTER = 1'b1;

    // Decoded beat handed from the byte decoder to the arithmetic stages
    typedef struct packed {
        logic        cand;   // completed non-sparse run, count still to check
        logic        endv;   // an end report follows the run
        logic [1:0]  endk;   // kind of that end report
        logic [63:0] clus;   // cluster count of the run
        logic [63:0] lcn;    // running LCN after the delta
    } t_run;

endpackage

@@ rtl/ntfs_data_run_decoder_unit.sv @@
// Top level of the NTFS run-list decoder: config registers, multiply and add stages,
// output sequencing. Depends on ntfsdr_pkg and ntfsdr_decode.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one run-list byte per beat with
//   i_list_last marking the final byte of a list. Output channel (o_out_valid /
//   i_out_ready) carries decoded runs (start sector, sector count) and end reports
//   (kind END or TRUNC, zero payload). o_last_of_run flags the last result that a
//   given input byte produced; a byte yields zero, one or two results.
//   Configuration goes through the APB port: volume_start_sector at 0x0,
//   sectors_per_cluster at 0x8 (13 bits). Write it only while the block is idle.
// Pipeline: an accepted byte passes through decode, multiply and add, then the
//   output register.
// Throughput: one byte per cycle while i_out_ready holds. Bytes with no result
//   leave no trace in the stages; a byte with two results occupies the output
//   register for both. The output register sets the rate, one result per ready cycle.
// Reset: synchronous, active low; clears run-list state and all stage valids,
//   volume start to 0 and sectors per cluster to 8.
// Stall: each stage holds while the one below is full and blocked, so empty
//   stages keep absorbing bytes while a finished result waits to be taken.
module ntfs_data_run_decoder_unit import ntfsdr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input byte stream
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_run_byte,
    input  logic              i_list_last,
    // result stream
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [63:0]       o_start_sector,
    output logic [63:0]       o_sector_count,
    output logic [1:0]        o_kind,
    output logic              o_last_of_run,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [63:0]      r_vol;
    logic [SPC_W-1:0] r_spc;

    // stage A (decoder output)
    logic             a_valid;
    t_run             a_run;

    // stage B: partial products
    logic             r_b_valid;
    logic             r_b_cand;
    logic             r_b_endv;
    logic [1:0]       r_b_endk;
    logic [44:0]      r_b_cl;
    logic [31:0]      r_b_ch;
    logic [44:0]      r_b_ll;
    logic [31:0]      r_b_lh;

    // stage C: full sums
    logic             r_c_valid;
    logic             r_c_cand;
    logic             r_c_endv;
    logic [1:0]       r_c_endk;
    logic [63:0]      r_c_count;
    logic [63:0]      r_c_start;

    // stage D: output register, up to two pending results
    logic             r_d_run;
    logic             r_d_end;
    logic [1:0]       r_d_endk;
    logic [63:0]      r_d_start;
    logic [63:0]      r_d_count;

    logic             accept;
    logic             cfg_write;
    logic             d_done;
    logic             d_free;
    logic             c_free;
    logic             b_free;
    logic             a_free;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol <= 64'd0;
            r_spc <= SPC_RESET;
        end else if (cfg_write) begin
            // register select is paddr[3]; low address bits are don't-care
            if (paddr[3] == REG_VOLUME_START) begin
                r_vol <= pwdata;
            end else begin
                r_spc <= pwdata[SPC_W-1:0];
            end
        end
    end

    assign prdata = (paddr[3] == REG_SECTORS_PER_CLUSTER) ?
                    {{(DATA_W-SPC_W){1'b0}}, r_spc} : r_vol;

    // ---------------- flow control ----------------
    // An item leaves D once its last result goes out.
    assign o_out_valid = r_d_run || r_d_end;
    assign d_done      = o_out_valid && i_out_ready && !(r_d_run && r_d_end);
    assign d_free      = !o_out_valid || d_done;
    assign c_free      = !r_c_valid || d_free;
    assign b_free      = !r_b_valid || c_free;
    assign a_free      = !a_valid || b_free;
    assign o_in_ready  = a_free;
    assign accept      = i_in_valid && a_free;

    // ---------------- stage A: byte decode ----------------
    ntfsdr_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_load      (a_free),
        .i_run_byte  (i_run_byte),
        .i_list_last (i_list_last),
        .o_valid     (a_valid),
        .o_run       (a_run)
    );

    // ---------------- stage B: split 64x13 multiplies ----------------
    // Low halves keep the full product, high halves only the bits below 2^64.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free) begin
            r_b_cand <= a_run.cand;
            r_b_endv <= a_run.endv;
            r_b_endk <= a_run.endk;
            r_b_cl   <= {13'd0, a_run.clus[31:0]} * {32'd0, r_spc};
            r_b_ch   <= a_run.clus[63:32] * {19'd0, r_spc};
            r_b_ll   <= {13'd0, a_run.lcn[31:0]} * {32'd0, r_spc};
            r_b_lh   <= a_run.lcn[63:32] * {19'd0, r_spc};
        end
    end

    // ---------------- stage C: recombine and add volume start ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_free) begin
            r_c_cand  <= r_b_cand;
            r_c_endv  <= r_b_endv;
            r_c_endk  <= r_b_endk;
            r_c_count <= {19'd0, r_b_cl} + {r_b_ch, 32'd0};
            r_c_start <= r_vol + {19'd0, r_b_ll} + {r_b_lh, 32'd0};
        end
    end

    // ---------------- stage D: output register ----------------
    // Drop runs whose sector count came out zero; hold the end
    // report behind the run result when a byte gave both.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_run <= 1'b0;
            r_d_end <= 1'b0;
        end else if (d_free) begin
            r_d_run <= r_c_valid && r_c_cand && (r_c_count != 64'd0);
            r_d_end <= r_c_valid && r_c_endv;
        end else if (o_out_valid && i_out_ready) begin
            // first of two results taken: advance to the end report
            r_d_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_free) begin
            r_d_endk  <= r_c_endk;
            r_d_start <= r_c_start;
            r_d_count <= r_c_count;
        end
    end

    assign o_start_sector = r_d_run ? r_d_start : 64'd0;
    assign o_sector_count = r_d_run ? r_d_count : 64'd0;
    assign o_kind         = r_d_run ? KIND_RUN : r_d_endk;
    assign o_last_of_run  = !(r_d_run && r_d_end);

    // ---------------- assertions ----------------
    a_end_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_RUN |-> o_start_sector == 64'd0 && o_sector_count == 64'd0)
        else $error("end report carries nonzero payload");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_RUN |-> o_sector_count != 64'd0)
        else $error("run result with zero sector count");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_run && r_d_end && i_out_ready |=> !r_d_run && r_d_end)
        else $error("end report lost after paired run result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !a_valid && !r_b_valid && !r_c_valid |-> o_in_ready)
        else $error("input blocked with empty stages");

endmodule

@@ rtl/ntfsdr_decode.sv @@
// Byte decoder of the NTFS run-list decoder: run-list state and first stage.
// Depends on ntfsdr_pkg.
module ntfsdr_decode import ntfsdr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_load,
    input  logic [7:0] i_run_byte,
    input  logic       i_list_last,
    output logic       o_valid,
    output t_run       o_run
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_COUNT  = 2'd1;
    localparam logic [1:0] PH_DELTA  = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [3:0]  r_len, n_len;
    logic [3:0]  r_off, n_off;
    logic [3:0]  r_pos, n_pos;
    logic [63:0] r_clus, n_clus;
    logic [63:0] r_delta, n_delta;
    logic [63:0] r_lcn, n_lcn;
    logic        r_fin, n_fin;
    logic        r_valid;
    t_run        r_run;

    t_run        item;
    logic        done;
    logic        clear;
    logic [3:0]  pos_inc;
    logic [63:0] ins;
    logic [63:0] delta_ins;
    logic [63:0] ext_mask;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            ext_mask[8*k +: 8] = (4'(k) >= r_off) ? 8'hFF : 8'h00;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_off     = r_off;
        n_pos     = r_pos;
        n_clus    = r_clus;
        n_delta   = r_delta;
        n_lcn     = r_lcn;
        n_fin     = r_fin;
        done      = 1'b0;
        clear     = 1'b0;
        item      = '0;
        item.endk = KIND_END;
        pos_inc   = r_pos + 4'd1;
        // bytes past the eighth of a field drop out
        ins       = r_pos[3] ? 64'd0 : ({56'd0, i_run_byte} << {r_pos[2:0], 3'b000});
        delta_ins = r_delta | ins;

        if (r_fin) begin
            // skip everything up to and including the last byte of the list
            clear = i_list_last;
        end else if (r_phase == PH_COUNT || r_phase == PH_DELTA) begin
            if (r_phase == PH_COUNT) begin
                n_clus = r_clus | ins;
                n_pos  = pos_inc;
                if (pos_inc >= r_len) begin
                    n_pos = 4'd0;
                    if (r_off != 4'd0) begin
                        n_phase = PH_DELTA;
                    end else begin
                        done = 1'b1;
                    end
                end
            end else begin
                n_delta = delta_ins;
                n_pos   = pos_inc;
                if (pos_inc >= r_off) begin
                    // sign-extend from the field's last byte when it is short
                    if (!r_off[3] && i_run_byte[7]) begin
                        n_delta = delta_ins | ext_mask;
                    end
                    done = 1'b1;
                end
            end
            if (done) begin
                n_phase = PH_HEADER;
                n_pos   = 4'd0;
                if (r_off != 4'd0) begin
                    n_lcn     = r_lcn + n_delta;
                    item.cand = 1'b1;
                    item.clus = n_clus;
                    item.lcn  = r_lcn + n_delta;
                end
            end
            if (i_list_last) begin
                item.endv = 1'b1;
                item.endk = done ? KIND_END : KIND_TRUNC;
                clear     = 1'b1;
            end
        end else begin
            if (i_run_byte == 8'h00) begin
                item.endv = 1'b1;
                item.endk = KIND_END;
                if (i_list_last) begin
                    clear = 1'b1;
                end else begin
                    n_fin = 1'b1;
                end
            end else begin
                n_len   = i_run_byte[3:0];
                n_off   = i_run_byte[7:4];
                n_pos   = 4'd0;
                n_clus  = 64'd0;
                n_delta = 64'd0;
                n_phase = (i_run_byte[3:0] != 4'd0) ? PH_COUNT : PH_DELTA;
                if (i_list_last) begin
                    item.endv = 1'b1;
                    item.endk = KIND_TRUNC;
                    clear     = 1'b1;
                end
            end
        end

        if (clear) begin
            n_phase = PH_HEADER;
            n_len   = 4'd0;
            n_off   = 4'd0;
            n_pos   = 4'd0;
            n_clus  = 64'd0;
            n_delta = 64'd0;
            n_lcn   = 64'd0;
            n_fin   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_len   <= 4'd0;
            r_off   <= 4'd0;
            r_pos   <= 4'd0;
            r_clus  <= 64'd0;
            r_delta <= 64'd0;
            r_lcn   <= 64'd0;
            r_fin   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_off   <= n_off;
                r_pos   <= n_pos;
                r_clus  <= n_clus;
                r_delta <= n_delta;
                r_lcn   <= n_lcn;
                r_fin   <= n_fin;
            end
            if (i_load) begin
                r_valid <= i_accept && (item.cand || item.endv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= item;
        end
    end

    assign o_valid = r_valid;
    assign o_run   = r_run;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for ntfs_data_run_decoder_unit: run-list bytes in, decoded runs out.
// Predicts every result in a scoreboard class and configures the block over APB.
// Depends on ntfsdr_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;
    import ntfsdr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {ST_HEADER, ST_COUNT, ST_DELTA} t_field_state;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_pattern;

    typedef struct packed {
        logic [63:0] start_sec;
        logic [63:0] sec_count;
        logic [1:0]  kind;
        logic        last;
    } t_run_result;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_byte_beat;

    // Tracks the decoder state and the results it owes, in acceptance order.
    class run_map_checker;
        logic [63:0]      vol_start;
        logic [SPC_W-1:0] spc;
        t_field_state     st;
        logic [3:0]       len_bytes;
        logic [3:0]       off_bytes;
        logic [3:0]       pos;
        logic [63:0]      clusters;
        logic [63:0]      delta;
        logic [63:0]      lcn;
        logic             skip_to_last;
        t_run_result      pending_runs[$];
        int unsigned      fails;

        function new();
            vol_start = '0;
            spc = SPC_RESET;
            fails = 0;
            clear_list();
        endfunction

        function void clear_list();
            st = ST_HEADER;
            len_bytes = '0;
            off_bytes = '0;
            pos = '0;
            clusters = '0;
            delta = '0;
            lcn = '0;
            skip_to_last = 1'b0;
        endfunction

        function int pending();
            return pending_runs.size();
        endfunction

        function t_run_result report(logic [1:0] kind);
            t_run_result r;
            r = '0;
            r.kind = kind;
            return r;
        endfunction

        // Close the run in progress; sparse runs and empty runs produce nothing.
        function void close_run(ref t_run_result res[$]);
            logic [63:0] spc64;
            logic [63:0] cnt;
            t_run_result r;
            spc64 = {{(64 - SPC_W){1'b0}}, spc};
            cnt = clusters * spc64;
            st = ST_HEADER;
            pos = '0;
            if (off_bytes == 0) return;
            lcn = lcn + delta;
            if (cnt == 0) return;
            r.start_sec = vol_start + lcn * spc64;
            r.sec_count = cnt;
            r.kind = KIND_RUN;
            r.last = 1'b0;
            res = {res, r};
        endfunction

        function void decode_byte(logic [7:0] b, logic last);
            t_run_result res[$];
            logic done;
            done = 1'b0;
            if (skip_to_last) begin
                if (last) clear_list();
                return;
            end
            if (st != ST_HEADER) begin
                if (st == ST_COUNT) begin
                    if (pos < 8) clusters = clusters | (64'(b) << (8 * pos));
                    pos = pos + 1'b1;
                    if (pos >= len_bytes) begin
                        pos = '0;
                        if (off_bytes > 0) st = ST_DELTA;
                        else done = 1'b1;
                    end
                end else begin
                    if (pos < 8) delta = delta | (64'(b) << (8 * pos));
                    pos = pos + 1'b1;
                    if (pos >= off_bytes) begin
                        // sign-extend from the top byte of a short delta
                        if (off_bytes < 8 && b[7]) delta = delta | (~64'd0 << (8 * off_bytes));
                        done = 1'b1;
                    end
                end
                if (done) close_run(res);
                if (last) begin
                    res = {res, report(done ? KIND_END : KIND_TRUNC)};
                    clear_list();
                end
            end else if (b == 8'h00) begin
                res = {res, report(KIND_END)};
                if (last) clear_list();
                else skip_to_last = 1'b1;
            end else begin
                len_bytes = b[3:0];
                off_bytes = b[7:4];
                pos = '0;
                clusters = '0;
                delta = '0;
                st = (len_bytes > 0) ? ST_COUNT : ST_DELTA;
                if (last) begin
                    res = {res, report(KIND_TRUNC)};
                    clear_list();
                end
            end
            if (res.size() > 0) res[res.size() - 1].last = 1'b1;
            pending_runs = {pending_runs, res};
        endfunction

        function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
                fails++;
            end
        endfunction

        function void compare_run(t_run_result act);
            t_run_result exp_r;
            if (pending_runs.size() == 0) begin
                $error("unexpected result: start %h count %h kind %0d",
                       act.start_sec, act.sec_count, act.kind);
                fails++;
                return;
            end
            exp_r = pending_runs.pop_front();
            check_field("start_sector", exp_r.start_sec, act.start_sec);
            check_field("sector_count", exp_r.sec_count, act.sec_count);
            check_field("kind", 64'(exp_r.kind), 64'(act.kind));
            check_field("last_of_run", 64'(exp_r.last), 64'(act.last));
        endfunction
    endclass

    // DUT signals; everything starts at a known value, reset held low
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_run_byte = '0;
    logic              i_list_last = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [63:0]       o_start_sector;
    logic [63:0]       o_sector_count;
    logic [1:0]        o_kind;
    logic              o_last_of_run;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    run_map_checker sb;
    t_byte_beat     stim_q[$];
    t_rx_pattern    rx_mode = RX_FREE;
    logic           tx_gaps = 1'b0;
    int             hold_req = 0;
    int             idle_cycles = 0;

    ntfs_data_run_decoder_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_run_byte     (i_run_byte),
        .i_list_last    (i_list_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_start_sector (o_start_sector),
        .o_sector_count (o_sector_count),
        .o_kind         (o_kind),
        .o_last_of_run  (o_last_of_run),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every result beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.compare_run('{o_start_sector, o_sector_count, o_kind, o_last_of_run});
    end

    // Watchdog: end the run when neither channel nor the config port moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[ntfs_data_run_decoder_unit] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result-side back-pressure. A hold-off request freezes ready low for a long
    // stretch so the pipeline fills and stalls the byte stream; otherwise follow
    // the pattern chosen for the current phase.
    initial begin : out_ready_gen
        int hold;
        int tick;
        hold = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_req > 0) begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:     i_out_ready <= 1'b1;
                    RX_LIGHT:    i_out_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY:    i_out_ready <= ($urandom_range(0, 1) != 0);
                    RX_PERIODIC: i_out_ready <= (tick % 8 >= 3);
                    default:     i_out_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        // setup phase, then access phase; the register takes the value on the access edge
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_volume(logic [63:0] vol);
        apb_write({REG_VOLUME_START, 3'b000}, vol);
        sb.vol_start = vol;
    endtask

    task automatic set_cluster_size(logic [SPC_W-1:0] n);
        apb_write({REG_SECTORS_PER_CLUSTER, 3'b000}, {{(DATA_W - SPC_W){1'b0}}, n});
        sb.spc = n;
    endtask

    task automatic add_beat(logic [7:0] value, logic last);
        stim_q = {stim_q, t_byte_beat'{value, last}};
    endtask

    function automatic logic [7:0] field_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // Append one run list. Mostly well-formed lists with random field content,
    // ending cleanly, with trailing junk, right after a run, or cut mid-run;
    // the rest is plain noise.
    task automatic gen_list();
        int n;
        int nruns;
        int ending;
        int len;
        int off;
        int total;
        int stop;
        logic final_run;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) add_beat(8'($urandom), i == n - 1);
            return;
        end
        nruns = $urandom_range(1, 5);
        ending = $urandom_range(0, 3);
        for (int r = 0; r < nruns; r++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
            off = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
            if (len == 0 && off == 0) len = 1;
            total = 1 + len + off;
            final_run = (r == nruns - 1);
            stop = total - 1;
            if (final_run && ending == 3) stop = $urandom_range(0, total - 2);
            for (int i = 0; i <= stop; i++)
                add_beat((i == 0) ? 8'(off * 16 + len) : field_byte(),
                         final_run && ending >= 2 && i == stop);
        end
        if (ending == 0) begin
            add_beat(8'h00, 1'b1);
        end else if (ending == 1) begin
            // end marker without last: everything up to the last byte is skipped
            add_beat(8'h00, 1'b0);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) add_beat(8'($urandom), 1'b0);
            add_beat(8'($urandom), 1'b1);
        end
    endtask

    task automatic add_directed();
        // runs with positive and negative deltas, a sparse run and a zero-length run; end marker
        // with skipped bytes after it
        add_beat(8'h11, 1'b0); add_beat(8'h05, 1'b0); add_beat(8'h02, 1'b0);
        add_beat(8'h21, 1'b0); add_beat(8'h03, 1'b0); add_beat(8'hFF, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h01, 1'b0); add_beat(8'h07, 1'b0);
        add_beat(8'h11, 1'b0); add_beat(8'h00, 1'b0); add_beat(8'h05, 1'b0);
        add_beat(8'h00, 1'b0); add_beat(8'hAA, 1'b0); add_beat(8'h3C, 1'b1);
        // last flag right after a run completes
        add_beat(8'h11, 1'b0); add_beat(8'h01, 1'b0); add_beat(8'h80, 1'b1);
        // last flag on an end marker
        add_beat(8'h00, 1'b1);
        // last flag in the middle of a run, and on a header
        add_beat(8'h22, 1'b0); add_beat(8'h01, 1'b1);
        add_beat(8'hF0, 1'b1);
    endtask

    // Drive the byte stream in bursts; valid holds until the beat is taken.
    task automatic send_bytes();
        int burst;
        int gap;
        burst = 0;
        while (stim_q.size() > 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap = tx_gaps ? $urandom_range(0, 6) : 0;
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_in_valid <= 1'b1;
            i_run_byte <= stim_q[0].value;
            i_list_last <= stim_q[0].last;
            do @(posedge i_clk); while (!o_in_ready);
            sb.decode_byte(stim_q[0].value, stim_q[0].last);
            void'(stim_q.pop_front());
            burst--;
        end
        i_in_valid <= 1'b0;
    endtask

    // Wait out every pending result, then the pipeline depth for bytes that owe nothing.
    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : main_seq
        int target;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: target = 300;
                1: begin
                    set_volume(64'hFFFF_FFFF_FFFF_FFFF);
                    set_cluster_size(13'd1);
                    target = 350;
                end
                2: begin
                    set_volume({$urandom, $urandom});
                    set_cluster_size(13'd4096);
                    target = 350;
                end
                3: begin
                    set_volume(64'd0);
                    set_cluster_size(13'h1FFF);
                    target = 300;
                end
                4: begin
                    set_volume({$urandom, $urandom});
                    set_cluster_size(13'd0);
                    target = 150;
                end
                default: begin
                    set_volume({$urandom, $urandom});
                    set_cluster_size(13'($urandom_range(1, 4096)));
                    target = 450;
                end
            endcase
            // first phase runs with no idling on either side
            rx_mode = (ph == 0) ? RX_FREE : t_rx_pattern'($urandom_range(0, 3));
            tx_gaps = (ph != 0) && (ph != 2);
            if (ph == 0) add_directed();
            while (stim_q.size() < target) gen_list();
            // starve the output while bytes keep coming
            if (ph == 2) hold_req = HOLD_OFF_CYCLES;
            send_bytes();
            wait_drained();
        end
        if (sb.fails == 0) begin
            $display("[ntfs_data_run_decoder_unit] OK");
        end else begin
            $display("[ntfs_data_run_decoder_unit] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ntfsdr_pkg.sv
rtl/ntfsdr_decode.sv
rtl/ntfs_data_run_decoder_unit.sv
test/tb_top.sv
